FILE: hdl/pmt_pkg.sv
// Shared types and constants for the phase current polarity mean tracker.
`timescale 1ns / 1ps

package pmt_pkg;

  localparam int unsigned NUM_PHASES  = 3;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned MEAN_W      = 16;
  localparam int unsigned POS_W       = 15;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 96;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - NUM_PHASES * (MEAN_W + POS_W);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [MEAN_W-1:0] mean_t;

  // Six means of one sample; the positive group sits in the low bits.
  typedef struct packed {
    logic [NUM_PHASES-1:0][MEAN_W-1:0] neg;
    logic [NUM_PHASES-1:0][POS_W-1:0]  pos;
  } pmt_means_t;

endpackage

FILE: hdl/pmt_lane.sv
// One leaky accumulator with its constant reciprocal divider.
`timescale 1ns / 1ps

module pmt_lane import pmt_pkg::*; #(
  parameter int unsigned SAMPLE_COUNT = 8096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [SAMPLE_W-1:0] add_val,
  output mean_t               mean
);

  // The accumulator stays below 32769 * SAMPLE_COUNT.
  localparam int unsigned LOG_N = $clog2(SAMPLE_COUNT);
  localparam int unsigned ACC_W = LOG_N + SAMPLE_W;
  localparam int unsigned SHIFT = ACC_W + LOG_N;
  // Rounded-up reciprocal, exact for every accumulator value.
  localparam logic [ACC_W:0] RECIP = (ACC_W + 1)'(
      ((64'd1 << SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;
  logic [2*ACC_W:0] prod;
  mean_t            quot;

  assign prod = {{(ACC_W + 1){1'b0}}, acc} * {{ACC_W{1'b0}}, RECIP};
  assign quot = prod[SHIFT +: MEAN_W];

  // Leak the current mean, then add the sample magnitude.
  assign acc_next = acc - ACC_W'(quot) + ACC_W'(add_val);
  assign mean     = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (load) begin
      acc <= acc_next;
    end
  end

endmodule

FILE: hdl/pmt_merge.sv
// Output register that gathers the six lane means into one result beat.
`timescale 1ns / 1ps

module pmt_merge import pmt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load_valid,
  input  pmt_means_t             means,
  output logic                   advance,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  pmt_means_t hold;

  // The register can take a new result when it is empty or being drained.
  assign advance = !m_tvalid || m_tready;
  assign m_tdata = {{OUT_PAD_W{1'b0}}, hold};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      hold <= means;
    end
  end

endmodule

FILE: hdl/phase_current_polarity_mean_tracker_top.sv
// Top level of the phase current polarity mean tracker.
`timescale 1ns / 1ps

// Channel   Direction  Beat contents (lowest bits first)
// s_*       in         phase_a_current[15:0], phase_b_current[31:16], phase_c_current[47:32]
// m_*       out        avg_pos_a/b/c (15 bits each), avg_neg_a/b/c (16 bits each), 3 zero bits
//
// Flow: one sample beat per cycle while the output is not stalled; a result beat passes
// through the lane accumulators and then the output register. The rate is set by the
// accumulator loop in each lane: reciprocal multiply, subtract and add all lie inside it.
// Reset: synchronous; clears all six accumulators and both valid flags, no clearing pass.
// Stalls: a held result keeps its beat; at most one more sample is taken into the accumulators,
// after which s_tready drops until the output drains.

module phase_current_polarity_mean_tracker_top import pmt_pkg::*; #(
  parameter int unsigned SAMPLE_COUNT = 8096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // phase_a_current[15:0], phase_b_current[31:16], phase_c_current[47:32]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // avg_pos_a[14:0], avg_pos_b[29:15], avg_pos_c[44:30],
  // avg_neg_a[60:45], avg_neg_b[76:61], avg_neg_c[92:77], zero pad[95:93]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  logic       s_accept;
  logic       stage_valid;   // accumulators hold a result not yet in the output register
  logic       advance;
  pmt_means_t means;

  // Take a sample unless the accumulators hold a result that cannot move on.
  assign s_tready = !stage_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= s_accept || (stage_valid && !advance);
    end
  end

  // One positive and one negative lane per phase.
  for (genvar p = 0; p < NUM_PHASES; p++) begin : g_phase
    sample_t             sample;
    logic                is_neg;
    logic [SAMPLE_W-1:0] pos_add;
    logic [SAMPLE_W-1:0] neg_add;
    mean_t               pos_mean;
    mean_t               neg_mean;

    assign sample = s_tdata[p*SAMPLE_W +: SAMPLE_W];
    assign is_neg = sample[SAMPLE_W-1];
    // Zero counts as positive; the negative side adds the magnitude.
    assign pos_add = is_neg ? '0 : sample;
    assign neg_add = is_neg ? (~sample + 1'b1) : '0;

    pmt_lane #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_pos (
      .clk     (clk),
      .rst     (rst),
      .load    (s_accept),
      .add_val (pos_add),
      .mean    (pos_mean)
    );

    pmt_lane #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_neg (
      .clk     (clk),
      .rst     (rst),
      .load    (s_accept),
      .add_val (neg_add),
      .mean    (neg_mean)
    );

    // Positive means never exceed 32767.
    assign means.pos[p] = pos_mean[POS_W-1:0];
    assign means.neg[p] = neg_mean;
  end

  pmt_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load_valid (stage_valid),
    .means      (means),
    .advance    (advance),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

FILE: hdl/pmt_checker.sv
// Port-level checks for the phase current polarity mean tracker.
`timescale 1ns / 1ps

module pmt_checker import pmt_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("sample side blocked without an output stall");

  a_sample_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 (m_tready || !m_tvalid) |=> m_tvalid)
    else $error("accepted sample produced no result beat");

endmodule

bind phase_current_polarity_mean_tracker_top pmt_checker u_pmt_checker (.*);
